// ===== hdl/clpm_pkg.sv =====
// Shared constants, register codes and control types for the lag product mean block.
package clpm_pkg;

  localparam int MAX_LAG   = 255;
  localparam int MAX_TIME  = 4096;

  localparam int SAMPLE_W  = 16;
  localparam int LAG_W     = 9;
  localparam int TC_W      = 13;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int MEAN_W    = 33;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int DLY_W     = 2 * SAMPLE_W;
  localparam int SUM_W     = 45;
  localparam int ADDR_W    = $clog2(MAX_LAG);
  localparam int DIV_W     = SUM_W - 1;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [CFG_IDX_W-1:0] REG_LAG       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_SIZE = 1'b1;

  typedef struct packed {
    logic capture;
    logic mul;
    logic acc;
    logic div_load;
    logic div_step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic gate_end;
    logic div_done;
  } dp_status_t;

endpackage

// ===== hdl/clpm_if.sv =====
// Valid/ready channel interfaces for sample beats and mean result beats.
interface clpm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [clpm_pkg::SAMPLE_W-1:0]  first_re;
  logic signed [clpm_pkg::SAMPLE_W-1:0]  first_im;
  logic signed [clpm_pkg::SAMPLE_W-1:0]  second_re;
  logic signed [clpm_pkg::SAMPLE_W-1:0]  second_im;

  modport source(output valid, first_re, first_im, second_re, second_im, input ready);
  modport sink(input valid, first_re, first_im, second_re, second_im, output ready);
endinterface

interface clpm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [clpm_pkg::MEAN_W-1:0]  mean_re;
  logic signed [clpm_pkg::MEAN_W-1:0]  mean_im;

  modport source(output valid, mean_re, mean_im, input ready);
  modport sink(input valid, mean_re, mean_im, output ready);
endinterface

// ===== hdl/clpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module clpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 255,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/clpm_datapath.sv =====
// Datapath: config registers, delay line, complex multiply, accumulators, divider.
module clpm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [clpm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [clpm_pkg::CFG_W-1:0]            cfg_data,
  input  clpm_pkg::dp_cmd_t                     cmd,
  output clpm_pkg::dp_status_t                  status,
  input  logic signed [clpm_pkg::SAMPLE_W-1:0]  first_re,
  input  logic signed [clpm_pkg::SAMPLE_W-1:0]  first_im,
  input  logic signed [clpm_pkg::SAMPLE_W-1:0]  second_re,
  input  logic signed [clpm_pkg::SAMPLE_W-1:0]  second_im,
  output logic signed [clpm_pkg::MEAN_W-1:0]    mean_re,
  output logic signed [clpm_pkg::MEAN_W-1:0]    mean_im
);

  localparam int PSUM_W = clpm_pkg::ADDR_W + 2;

  logic signed [clpm_pkg::LAG_W-1:0]    lag;
  logic [clpm_pkg::TC_W-1:0]            gate_size;
  logic [clpm_pkg::ADDR_W-1:0]          wr_ptr;
  logic [clpm_pkg::TC_W-1:0]            time_index;
  logic signed [clpm_pkg::SUM_W-1:0]    sum_re;
  logic signed [clpm_pkg::SUM_W-1:0]    sum_im;
  logic signed [clpm_pkg::SAMPLE_W-1:0] x1r, x1i, x2r, x2i;
  logic signed [clpm_pkg::PROD_W-1:0]   p_rr, p_ii, p_ir, p_ri;
  logic [clpm_pkg::TC_W-1:0]            rem_re, rem_im;
  logic [clpm_pkg::DIV_W-1:0]           dq_re, dq_im;
  logic                                 neg_re, neg_im;
  logic [clpm_pkg::DIV_CNT_W-1:0]       div_cnt;

  logic [clpm_pkg::LAG_W-1:0]           mag;
  logic                                 lag_neg;
  logic                                 lag_ok;
  logic                                 use_delay;
  logic                                 acc_ok;
  logic [PSUM_W-1:0]                    rd_sum;
  logic [clpm_pkg::ADDR_W-1:0]          rd_addr;
  logic [clpm_pkg::DLY_W-1:0]           wr_data;
  logic [clpm_pkg::DLY_W-1:0]           rd_data;
  logic signed [clpm_pkg::SAMPLE_W-1:0] d_re, d_im;
  logic signed [clpm_pkg::SAMPLE_W-1:0] a_re, a_im, b_re, b_im;
  logic [clpm_pkg::TC_W-1:0]            tc_in;
  logic signed [clpm_pkg::SUM_W-1:0]    abs_re, abs_im;
  logic [clpm_pkg::TC_W:0]              trial_re, trial_im;
  logic                                 ge_re, ge_im;
  logic [clpm_pkg::MEAN_W-1:0]          q_re, q_im;

  assign lag_neg   = lag[clpm_pkg::LAG_W-1];
  assign mag       = lag_neg ? clpm_pkg::LAG_W'(-lag) : clpm_pkg::LAG_W'(lag);
  assign lag_ok    = mag <= clpm_pkg::LAG_W'(clpm_pkg::MAX_LAG);
  assign use_delay = mag != '0;
  assign acc_ok    = lag_ok && (time_index >= clpm_pkg::TC_W'(mag));

  // delay tap: (wr_ptr - mag) mod MAX_LAG
  always_comb begin
    rd_sum = PSUM_W'(wr_ptr) + PSUM_W'(clpm_pkg::MAX_LAG) - PSUM_W'(mag);
    if (rd_sum >= PSUM_W'(clpm_pkg::MAX_LAG)) begin
      rd_addr = clpm_pkg::ADDR_W'(rd_sum - PSUM_W'(clpm_pkg::MAX_LAG));
    end else begin
      rd_addr = clpm_pkg::ADDR_W'(rd_sum);
    end
  end

  assign wr_data = lag_neg ? {x1i, x1r} : {x2i, x2r};

  clpm_ram #(
    .WIDTH(clpm_pkg::DLY_W),
    .DEPTH(clpm_pkg::MAX_LAG)
  ) u_delay (
    .clk  (clk),
    .we   (cmd.mul),
    .waddr(wr_ptr),
    .wdata(wr_data),
    .re   (cmd.capture),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign d_re = signed'(rd_data[clpm_pkg::SAMPLE_W-1:0]);
  assign d_im = signed'(rd_data[clpm_pkg::DLY_W-1:clpm_pkg::SAMPLE_W]);
  assign a_re = (use_delay && lag_neg)  ? d_re : x1r;
  assign a_im = (use_delay && lag_neg)  ? d_im : x1i;
  assign b_re = (use_delay && !lag_neg) ? d_re : x2r;
  assign b_im = (use_delay && !lag_neg) ? d_im : x2i;

  always_comb begin
    tc_in = cfg_data[clpm_pkg::TC_W-1:0];
    if (tc_in == '0) begin
      tc_in = clpm_pkg::TC_W'(1);
    end else if (tc_in > clpm_pkg::TC_W'(clpm_pkg::MAX_TIME)) begin
      tc_in = clpm_pkg::TC_W'(clpm_pkg::MAX_TIME);
    end
  end

  assign status.gate_end = ({1'b0, time_index} + (clpm_pkg::TC_W+1)'(1)) >= {1'b0, gate_size};
  assign status.div_done = div_cnt == clpm_pkg::DIV_CNT_W'(clpm_pkg::DIV_W - 1);

  // restoring divider, one quotient bit per lane per cycle
  assign abs_re   = sum_re[clpm_pkg::SUM_W-1] ? -sum_re : sum_re;
  assign abs_im   = sum_im[clpm_pkg::SUM_W-1] ? -sum_im : sum_im;
  assign trial_re = {rem_re, dq_re[clpm_pkg::DIV_W-1]};
  assign trial_im = {rem_im, dq_im[clpm_pkg::DIV_W-1]};
  assign ge_re    = trial_re >= {1'b0, gate_size};
  assign ge_im    = trial_im >= {1'b0, gate_size};
  assign q_re     = dq_re[clpm_pkg::MEAN_W-1:0];
  assign q_im     = dq_im[clpm_pkg::MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      lag        <= '0;
      gate_size  <= clpm_pkg::TC_W'(1);
      wr_ptr     <= '0;
      time_index <= '0;
      sum_re     <= '0;
      sum_im     <= '0;
      div_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          clpm_pkg::REG_LAG:       lag <= signed'(cfg_data[clpm_pkg::LAG_W-1:0]);
          clpm_pkg::REG_GATE_SIZE: gate_size <= tc_in;
          default: ;
        endcase
        time_index <= '0;
        sum_re     <= '0;
        sum_im     <= '0;
      end
      if (cmd.mul) begin
        wr_ptr <= (wr_ptr == clpm_pkg::ADDR_W'(clpm_pkg::MAX_LAG - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd.acc) begin
        if (acc_ok) begin
          sum_re <= sum_re + clpm_pkg::SUM_W'(p_rr) + clpm_pkg::SUM_W'(p_ii);
          sum_im <= sum_im + clpm_pkg::SUM_W'(p_ir) - clpm_pkg::SUM_W'(p_ri);
        end
        time_index <= status.gate_end ? '0 : time_index + 1'b1;
      end
      if (cmd.div_load) begin
        sum_re  <= '0;
        sum_im  <= '0;
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x1r <= first_re;
      x1i <= first_im;
      x2r <= second_re;
      x2i <= second_im;
    end
    if (cmd.mul) begin
      p_rr <= a_re * b_re;
      p_ii <= a_im * b_im;
      p_ir <= a_im * b_re;
      p_ri <= a_re * b_im;
    end
    if (cmd.div_load) begin
      neg_re <= sum_re[clpm_pkg::SUM_W-1];
      neg_im <= sum_im[clpm_pkg::SUM_W-1];
      dq_re  <= abs_re[clpm_pkg::DIV_W-1:0];
      dq_im  <= abs_im[clpm_pkg::DIV_W-1:0];
      rem_re <= '0;
      rem_im <= '0;
    end
    if (cmd.div_step) begin
      rem_re <= ge_re ? clpm_pkg::TC_W'(trial_re - {1'b0, gate_size})
                      : trial_re[clpm_pkg::TC_W-1:0];
      rem_im <= ge_im ? clpm_pkg::TC_W'(trial_im - {1'b0, gate_size})
                      : trial_im[clpm_pkg::TC_W-1:0];
      dq_re  <= {dq_re[clpm_pkg::DIV_W-2:0], ge_re};
      dq_im  <= {dq_im[clpm_pkg::DIV_W-2:0], ge_im};
    end
    if (cmd.load) begin
      mean_re <= neg_re ? -signed'(q_re) : signed'(q_re);
      mean_im <= neg_im ? -signed'(q_im) : signed'(q_im);
    end
  end

endmodule

// ===== hdl/clpm_ctrl.sv =====
// Controller: sequences capture, multiply, accumulate, divide and result hand-off.
module clpm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output clpm_pkg::dp_cmd_t    cmd,
  input  clpm_pkg::dp_status_t status
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state, state_next;
  logic       out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  assign cmd.capture  = in_valid && in_ready;
  assign cmd.mul      = state == S_MUL;
  assign cmd.acc      = state == S_ACC;
  assign cmd.div_load = state == S_DLOAD;
  assign cmd.div_step = state == S_DIV;
  assign cmd.load     = (state == S_OUT) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) begin
                 state_next = S_MUL;
               end
      S_MUL:   state_next = S_ACC;
      S_ACC:   state_next = status.gate_end ? S_DLOAD : S_IDLE;
      S_DLOAD: state_next = S_DIV;
      S_DIV:   if (status.div_done) begin
                 state_next = S_OUT;
               end
      S_OUT:   if (out_free) begin
                 state_next = S_IDLE;
               end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      priority if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/complex_lag_product_mean_top.sv =====
// Each sample beat goes through delay RAM read, complex multiply and accumulate before the next is taken.
// At gate end the mean is formed by divider load, 44 one-bit restoring divide steps and output load.
// The next sample beat is taken while a finished mean beat still waits in the output register.
// Reset (rst, synchronous): lag 0, gate length 1, empty gate, no result pending.
// Top level of the single-lag complex lag product mean block.
module complex_lag_product_mean_top (
  input  logic                           clk,
  input  logic                           rst,
  clpm_in_if.sink                        sample,
  clpm_out_if.source                     result,
  input  logic                           cfg_we,
  input  logic [clpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clpm_pkg::CFG_W-1:0]     cfg_data
);

  clpm_pkg::dp_cmd_t    cmd;
  clpm_pkg::dp_status_t status;

  clpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .cmd      (cmd),
    .status   (status)
  );

  clpm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .first_re (sample.first_re),
    .first_im (sample.first_im),
    .second_re(sample.second_re),
    .second_im(sample.second_im),
    .mean_re  (result.mean_re),
    .mean_im  (result.mean_im)
  );

endmodule

// ===== hdl/clpm_checker.sv =====
// Port-level checker for the lag product mean block, bound to the top level.
module clpm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [clpm_pkg::MEAN_W-1:0]  mean_re,
  input logic signed [clpm_pkg::MEAN_W-1:0]  mean_im
);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat pending right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample beat taken while previous sample still in work");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result beat raised right after a sample beat");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(mean_re) && $stable(mean_im))
    else $error("result beat payload changed while stalled");

endmodule

bind complex_lag_product_mean_top clpm_checker u_clpm_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (sample.valid),
  .in_ready (sample.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .mean_re  (result.mean_re),
  .mean_im  (result.mean_im)
);

// ===== bench/tb_complex_lag_product_mean_top.sv =====
// Self-checking bench: random I/Q beats against a lag product mean predictor.
`timescale 1ns / 1ps

module tb_complex_lag_product_mean_top;

  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1500000;

  typedef struct {
    logic signed [clpm_pkg::SAMPLE_W-1:0] first_re;
    logic signed [clpm_pkg::SAMPLE_W-1:0] first_im;
    logic signed [clpm_pkg::SAMPLE_W-1:0] second_re;
    logic signed [clpm_pkg::SAMPLE_W-1:0] second_im;
  } sample_t;

  typedef struct {
    logic [clpm_pkg::MEAN_W-1:0] re;
    logic [clpm_pkg::MEAN_W-1:0] im;
  } mean_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [clpm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [clpm_pkg::CFG_W-1:0]     cfg_data;

  clpm_in_if  sample_ch ();
  clpm_out_if result_ch ();

  complex_lag_product_mean_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sample_t samples_pending[$];
  mean_t   means_due[$];
  sample_t cur_beat;

  // predictor state
  logic [clpm_pkg::DLY_W-1:0] delay_line [clpm_pkg::MAX_LAG];
  int     wr_pos = 0;
  int     gate_pos = 0;
  int     gate_len = 1;
  int     cur_lag = 0;
  longint acc_re = 0;
  longint acc_im = 0;

  int  errors = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  hold_go;
  bit  calm;

  always #1 clk = ~clk;

  task automatic predict_mean(input sample_t s);
    int                         mag;
    bit                         neg;
    logic [clpm_pkg::DLY_W-1:0] held;
    longint                     ar, ai, br, bi;
    mean_t                      m;
    neg = cur_lag < 0;
    mag = neg ? -cur_lag : cur_lag;
    ar = s.first_re;
    ai = s.first_im;
    br = s.second_re;
    bi = s.second_im;
    if (mag > 0 && mag <= clpm_pkg::MAX_LAG) begin
      held = delay_line[(wr_pos + clpm_pkg::MAX_LAG - mag) % clpm_pkg::MAX_LAG];
      if (neg) begin
        ar = $signed(held[clpm_pkg::SAMPLE_W-1:0]);
        ai = $signed(held[clpm_pkg::DLY_W-1:clpm_pkg::SAMPLE_W]);
      end else begin
        br = $signed(held[clpm_pkg::SAMPLE_W-1:0]);
        bi = $signed(held[clpm_pkg::DLY_W-1:clpm_pkg::SAMPLE_W]);
      end
    end
    if (mag <= clpm_pkg::MAX_LAG && gate_pos >= mag) begin
      acc_re += ar * br + ai * bi;
      acc_im += ai * br - ar * bi;
    end
    delay_line[wr_pos] = neg ? {s.first_im, s.first_re} : {s.second_im, s.second_re};
    wr_pos = (wr_pos + 1) % clpm_pkg::MAX_LAG;
    gate_pos++;
    if (gate_pos >= gate_len) begin
      m.re = clpm_pkg::MEAN_W'(acc_re / gate_len);
      m.im = clpm_pkg::MEAN_W'(acc_im / gate_len);
      means_due.push_back(m);
      gate_pos = 0;
      acc_re = 0;
      acc_im = 0;
    end
  endtask

  function automatic logic [clpm_pkg::SAMPLE_W-1:0] pick_part();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return clpm_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic sample_t mk_sample(input logic [clpm_pkg::SAMPLE_W-1:0] a, b, c, d);
    sample_t s;
    s.first_re = a;
    s.first_im = b;
    s.second_re = c;
    s.second_im = d;
    return s;
  endfunction

  function automatic sample_t rand_sample();
    return mk_sample(pick_part(), pick_part(), pick_part(), pick_part());
  endfunction

  // upper bits above the lag field are don't-care
  function automatic logic [clpm_pkg::CFG_W-1:0] lag_code(input int lag);
    logic [clpm_pkg::LAG_W-1:0] l9;
    l9 = lag[clpm_pkg::LAG_W-1:0];
    return {(clpm_pkg::CFG_W - clpm_pkg::LAG_W)'($urandom_range(0, 15)), l9};
  endfunction

  task automatic write_reg(input logic [clpm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [clpm_pkg::CFG_W-1:0] value);
    int tcv;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == clpm_pkg::REG_LAG) begin
      cur_lag = $signed(value[clpm_pkg::LAG_W-1:0]);
    end else begin
      tcv = value[clpm_pkg::TC_W-1:0];
      if (tcv == 0) tcv = 1;
      if (tcv > clpm_pkg::MAX_TIME) tcv = clpm_pkg::MAX_TIME;
      gate_len = tcv;
    end
    gate_pos = 0;
    acc_re = 0;
    acc_im = 0;
  endtask

  task automatic queue_random(input int n);
    @(negedge clk);
    repeat (n) samples_pending.push_back(rand_sample());
  endtask

  task automatic settle();
    @(negedge clk);
    while (samples_pending.size() != 0 || sample_ch.valid || means_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) predict_mean(cur_beat);
      if (!sample_ch.valid || sample_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          sample_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 9);
          sample_ch.valid <= 1'b0;
        end else if (samples_pending.size() != 0) begin
          cur_beat = samples_pending.pop_front();
          sample_ch.valid     <= 1'b1;
          sample_ch.first_re  <= cur_beat.first_re;
          sample_ch.first_im  <= cur_beat.first_im;
          sample_ch.second_re <= cur_beat.second_re;
          sample_ch.second_im <= cur_beat.second_im;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      result_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(0, 9);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    mean_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (means_due.size() == 0) begin
        $error("unexpected mean beat: mean_re %0d, mean_im %0d",
               result_ch.mean_re, result_ch.mean_im);
        errors++;
      end else begin
        want = means_due.pop_front();
        if (result_ch.mean_re !== want.re) begin
          $error("mean_re: expected %0d, actual %0d", $signed(want.re), result_ch.mean_re);
          errors++;
        end
        if (result_ch.mean_im !== want.im) begin
          $error("mean_im: expected %0d, actual %0d", $signed(want.im), result_ch.mean_im);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int     lag_v, tc_v, gates, n, kind, mag, mask, extra;
    int     rand_items, rand_gates;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = clpm_pkg::REG_LAG;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.first_re = '0;
    sample_ch.first_im = '0;
    sample_ch.second_re = '0;
    sample_ch.second_im = '0;
    result_ch.ready = 1'b0;
    hold_go = 1'b0;
    calm = 1'b0;
    rand_items = 0;
    rand_gates = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: lag 0, one sample per gate
    @(negedge clk);
    samples_pending.push_back(mk_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    samples_pending.push_back(mk_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    samples_pending.push_back(mk_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
    samples_pending.push_back(mk_sample(16'hffff, 16'h0000, 16'h8000, 16'h7fff));
    settle();
    write_reg(clpm_pkg::REG_GATE_SIZE, 13'd0);
    queue_random(2);
    settle();
    // positive lag, then a partial gate dropped by a register write
    write_reg(clpm_pkg::REG_LAG, lag_code(3));
    write_reg(clpm_pkg::REG_GATE_SIZE, 13'd5);
    queue_random(7);
    settle();
    write_reg(clpm_pkg::REG_LAG, lag_code(-3));
    queue_random(5);
    settle();
    // lag out of range
    write_reg(clpm_pkg::REG_LAG, lag_code(-256));
    write_reg(clpm_pkg::REG_GATE_SIZE, 13'd2);
    queue_random(2);
    settle();
    // lag equal to gate length
    write_reg(clpm_pkg::REG_LAG, lag_code(5));
    write_reg(clpm_pkg::REG_GATE_SIZE, 13'd5);
    queue_random(5);
    settle();

    // output back-pressure fills the block
    write_reg(clpm_pkg::REG_LAG, lag_code(0));
    write_reg(clpm_pkg::REG_GATE_SIZE, 13'd1);
    hold_go = 1'b1;
    queue_random(80);
    settle();

    while (rand_items < 700) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        mag = $urandom_range(100, 256);
        lag_v = (mag == 256 || $urandom_range(0, 1)) ? -mag : mag;
        tc_v = mag + $urandom_range(0, 40);
        write_reg(clpm_pkg::REG_LAG, lag_code(lag_v));
        write_reg(clpm_pkg::REG_GATE_SIZE, clpm_pkg::CFG_W'(tc_v));
        gates = 1;
      end else begin
        lag_v = int'($urandom_range(0, 16)) - 8;
        tc_v = (kind == 3) ? (lag_v < 0 ? -lag_v : lag_v) : $urandom_range(1, 24);
        mask = $urandom_range(1, 3);
        if (mask[0]) write_reg(clpm_pkg::REG_LAG, lag_code(lag_v));
        if (mask[1]) write_reg(clpm_pkg::REG_GATE_SIZE, clpm_pkg::CFG_W'(tc_v));
        gates = (gate_len > 24) ? 1 : $urandom_range(1, 5);
      end
      n = gates * gate_len;
      extra = 0;
      if (gate_len > 1 && $urandom_range(0, 5) == 0) extra = $urandom_range(1, gate_len - 1);
      queue_random(n + extra);
      rand_items += n + extra;
      rand_gates += gates;
      settle();
    end

    // long gate at full scale
    write_reg(clpm_pkg::REG_LAG, lag_code(0));
    write_reg(clpm_pkg::REG_GATE_SIZE, 13'd400);
    @(negedge clk);
    repeat (400) samples_pending.push_back(mk_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    settle();

    calm = 1'b1;
    write_reg(clpm_pkg::REG_LAG, lag_code(-2));
    write_reg(clpm_pkg::REG_GATE_SIZE, 13'd10);
    queue_random(150);
    settle();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
